@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the path search block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define SSPS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define SSPS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ssps_pkg.sv @@
// Package of the shortest simple path search block: sizes, codes, states and
// the structs passed between its modules. Depends on nothing.
package ssps_pkg;

    localparam int CITIES      = 4;
    localparam int WEIGHT_BITS = 16;

    localparam int CITY_BITS   = 3;
    localparam int IN_W_BITS   = 16;
    localparam int DIST_BITS   = 19;
    localparam int IDX_BITS    = (CITIES > 2) ? $clog2(CITIES) : 1;
    localparam int CNT_BITS    = $clog2(CITIES + 1);
    localparam int ADDR_BITS   = 2 * IDX_BITS;
    localparam int STORE_BITS  = (WEIGHT_BITS < IN_W_BITS) ? WEIGHT_BITS : IN_W_BITS;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  addr;
        logic [STORE_BITS-1:0] data;
    } t_load_req;

    typedef struct packed {
        logic                start;
        logic [IDX_BITS-1:0] src;
        logic [IDX_BITS-1:0] dst;
    } t_query;

    typedef struct packed {
        logic                 valid;
        logic [CITY_BITS-1:0] city;
        logic [DIST_BITS-1:0] distance;
        logic                 last;
    } t_route_out;

endpackage

@@ rtl/core/ssps_road_ram.sv @@
// Road weight memory with one write port and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses ssps_pkg.
module ssps_road_ram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ssps_pkg::t_load_req            i_load,
    input  logic [ssps_pkg::ADDR_BITS-1:0] i_rd_addr,
    output logic [ssps_pkg::STORE_BITS-1:0] o_rd_data
);
    import ssps_pkg::*;

    localparam int DEPTH = 2 ** ADDR_BITS;

    logic [STORE_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]      r_vld;
    logic [STORE_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_load.we) begin
            r_mem[i_load.addr] <= i_load.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_load.we) begin
                r_vld[i_load.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/core/ssps_search.sv @@
// Depth-first search sequencer: path stack, visited set, best route store and
// route output. Reads road weights from ssps_road_ram. Uses ssps_pkg.
module ssps_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssps_pkg::t_query                i_query,
    input  logic [ssps_pkg::STORE_BITS-1:0] i_rd_data,
    input  logic                            i_out_stall,
    output logic [ssps_pkg::ADDR_BITS-1:0]  o_rd_addr,
    output logic                            o_busy,
    output ssps_pkg::t_route_out            o_route
);
    import ssps_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [IDX_BITS-1:0]  r_depth;
    logic [IDX_BITS-1:0]  r_city [CITIES];
    logic [CNT_BITS-1:0]  r_nb [CITIES];
    logic [DIST_BITS-1:0] r_dist [CITIES];
    logic [CITIES-1:0]    r_visited;
    logic [IDX_BITS-1:0]  r_cand;
    logic [IDX_BITS-1:0]  r_dest;
    logic [IDX_BITS-1:0]  r_best_route [CITIES];
    logic [CNT_BITS-1:0]  r_best_len;
    logic [DIST_BITS-1:0] r_best_dist;
    logic                 r_best_valid;
    logic [IDX_BITS-1:0]  r_out_idx;

    logic [CNT_BITS-1:0]  cur_nb;
    logic [IDX_BITS-1:0]  cand_idx;
    logic                 exhausted;
    logic                 cand_seen;
    logic [DIST_BITS:0]   dist_sum;
    logic [DIST_BITS-1:0] new_dist;
    logic                 at_dest;
    logic                 better;
    logic                 out_last;
    logic                 out_take;
    logic [IDX_BITS-1:0]  push_idx;

    assign cur_nb    = r_nb[r_depth];
    assign cand_idx  = cur_nb[IDX_BITS-1:0];
    assign exhausted = (cur_nb == CNT_BITS'(CITIES));
    assign cand_seen = r_visited[cand_idx];
    assign o_rd_addr = {r_city[r_depth], cand_idx};

    assign dist_sum = {1'b0, r_dist[r_depth]} + (DIST_BITS + 1)'(i_rd_data);
    assign new_dist = dist_sum[DIST_BITS] ? DIST_MAX : dist_sum[DIST_BITS-1:0];
    assign at_dest  = (r_cand == r_dest);
    assign better   = !r_best_valid || (new_dist < r_best_dist);
    assign push_idx = r_depth + IDX_BITS'(1);

    assign out_last = ((CNT_BITS'(r_out_idx) + CNT_BITS'(1)) == r_best_len);
    assign out_take = (r_state == ST_EMIT) && !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_query.start) begin
                    n_state = (i_query.src == i_query.dst) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (exhausted) begin
                    if (r_depth == '0) begin
                        n_state = r_best_valid ? ST_EMIT : ST_IDLE;
                    end
                end else if (!cand_seen) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_READ: begin
                n_state = ST_SCAN;
            end
            ST_EMIT: begin
                if (out_take && out_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control part of the search state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_visited    <= '0;
            r_best_valid <= 1'b0;
            r_out_idx    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_query.start) begin
                        r_depth      <= '0;
                        r_visited    <= CITIES'(1) << i_query.src;
                        r_best_valid <= (i_query.src == i_query.dst);
                        r_out_idx    <= '0;
                    end
                end
                ST_SCAN: begin
                    if (exhausted && (r_depth != '0)) begin
                        r_visited[r_city[r_depth]] <= 1'b0;
                        r_depth                    <= r_depth - IDX_BITS'(1);
                    end
                end
                ST_READ: begin
                    if (at_dest) begin
                        if (better) begin
                            r_best_valid <= 1'b1;
                        end
                    end else begin
                        r_visited[r_cand] <= 1'b1;
                        r_depth           <= push_idx;
                    end
                end
                ST_EMIT: begin
                    if (out_take) begin
                        r_out_idx <= r_out_idx + IDX_BITS'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Path stack and best route contents.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_query.start) begin
                    r_dest          <= i_query.dst;
                    r_city[0]       <= i_query.src;
                    r_nb[0]         <= '0;
                    r_dist[0]       <= '0;
                    r_best_route[0] <= i_query.src;
                    r_best_len      <= CNT_BITS'(1);
                    r_best_dist     <= '0;
                end
            end
            ST_SCAN: begin
                if (!exhausted) begin
                    r_nb[r_depth] <= cur_nb + CNT_BITS'(1);
                    r_cand        <= cand_idx;
                end
            end
            ST_READ: begin
                if (at_dest) begin
                    if (better) begin
                        for (int k = 0; k < CITIES; k++) begin
                            if (k <= int'(r_depth)) begin
                                r_best_route[k] <= r_city[k];
                            end else if (k == int'(r_depth) + 1) begin
                                r_best_route[k] <= r_cand;
                            end
                        end
                        r_best_len  <= CNT_BITS'(r_depth) + CNT_BITS'(2);
                        r_best_dist <= new_dist;
                    end
                end else begin
                    r_city[push_idx] <= r_cand;
                    r_nb[push_idx]   <= '0;
                    r_dist[push_idx] <= new_dist;
                end
            end
            default: ;
        endcase
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_route.valid    = (r_state == ST_EMIT);
    assign o_route.city     = CITY_BITS'(r_best_route[r_out_idx]);
    assign o_route.distance = r_best_dist;
    assign o_route.last     = out_last;

endmodule

@@ rtl/core/shortest_simple_path_search_top.sv @@
// Shortest simple path search over a small road matrix; uses ssps_pkg, ssps_road_ram
// and ssps_search. A load request is taken whenever the block is idle, and loads may run
// back to back. A query with distinct ends first searches (neighbour scans, weight reads,
// backtracks), then its route leaves at one city per cycle while i_stall is low;
// o_stall stays high until the last city is taken, so requests run one at a time.
// Synchronous active-low reset returns the block to idle and the road memory to zero.
module shortest_simple_path_search_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [2:0]           i_row,
    input  logic [2:0]           i_col,
    input  logic [15:0]          i_weight,
    input  logic [2:0]           i_source_city,
    input  logic [2:0]           i_dest_city,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_city,
    output logic [18:0]          o_distance,
    output logic                 o_last
);
    import ssps_pkg::*;

    // A request is taken only while the search sequencer is idle, so a query
    // and its route output never overlap with another request.
    logic                  accept;
    logic                  busy;
    logic                  row_ok;
    logic                  col_ok;
    logic                  src_ok;
    logic                  dst_ok;
    t_load_req             load;
    t_query                query;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [STORE_BITS-1:0] rd_data;
    t_route_out            route;

    assign accept = i_valid && !busy;

    // City numbers at or above the configured count are ignored: a load to such
    // a place is dropped, and such a query gives no route at all.
    assign row_ok = ({1'b0, i_row} < 4'(CITIES));
    assign col_ok = ({1'b0, i_col} < 4'(CITIES));
    assign src_ok = ({1'b0, i_source_city} < 4'(CITIES));
    assign dst_ok = ({1'b0, i_dest_city} < 4'(CITIES));

    // Only the low weight bits that the memory holds are kept.
    assign load.we   = accept && (i_req_type == REQ_LOAD) && row_ok && col_ok;
    assign load.addr = {i_row[IDX_BITS-1:0], i_col[IDX_BITS-1:0]};
    assign load.data = i_weight[STORE_BITS-1:0];

    assign query.start = accept && (i_req_type == REQ_QUERY) && src_ok && dst_ok;
    assign query.src   = i_source_city[IDX_BITS-1:0];
    assign query.dst   = i_dest_city[IDX_BITS-1:0];

    ssps_road_ram u_road_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The sequencer walks all simple paths depth-first, neighbours in
    // ascending order, and keeps the first strictly shortest one.
    ssps_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_query     (query),
        .i_rd_data   (rd_data),
        .i_out_stall (i_stall),
        .o_rd_addr   (rd_addr),
        .o_busy      (busy),
        .o_route     (route)
    );

    assign o_stall    = busy;
    assign o_valid    = route.valid;
    assign o_city     = route.city;
    assign o_distance = route.distance;
    assign o_last     = route.last;

endmodule

@@ rtl/core/ssps_checker.sv @@
// Port-level checker for the shortest simple path search block, bound to the
// top level. Uses the macros of assert_macros.svh.
`include "assert_macros.svh"

module ssps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_req_type,
    input logic [2:0]  i_row,
    input logic [2:0]  i_col,
    input logic [15:0] i_weight,
    input logic [2:0]  i_source_city,
    input logic [2:0]  i_dest_city,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_city,
    input logic [18:0] o_distance,
    input logic        o_last
);

    // No request is taken while a route is being delivered.
    `SSPS_ASSERT(a_busy_on_emit, i_clk, i_rst_n, o_valid |-> o_stall, "request taken during route")

    // A route keeps going until its last city has been taken.
    `SSPS_ASSERT(a_route_runs, i_clk, i_rst_n, (o_valid && !i_stall && !o_last) |=> o_valid, "route cut short")

    // Every city of one route carries the same total distance.
    `SSPS_ASSERT(a_dist_same, i_clk, i_rst_n, (o_valid && !i_stall && !o_last) |=> $stable(o_distance), "distance changed within route")

    // A stalled result holds.
    `SSPS_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_city) && $stable(o_last)), "stalled result changed")

    // Reset leaves the block idle and empty.
    `SSPS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_valid && !o_stall), "not idle after reset")

endmodule

bind shortest_simple_path_search_top ssps_checker u_ssps_checker (.*);
